>>> design/btkmh_pkg.sv
// ----------------------------------------------------------------------------
// btkmh_pkg: shared types and constants of the bounded top-k min-heap
// Entry layout, field widths, opcodes and defaults.
// ----------------------------------------------------------------------------
package btkmh_pkg;

  localparam int WEIGHT_W = 32;
  localparam int TAG_W    = 24;
  localparam int EDGE_W   = 8;
  localparam int CNT_W    = 7;

  localparam int HEAP_DEPTH_DEFAULT = 64;
  localparam logic [CNT_W-1:0] CAPACITY_RESET = 7'd64;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 104;
  localparam int OUT_USER_W = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DRAIN  = 1'b1;

  typedef struct packed {
    logic [EDGE_W-1:0]   edge_index;
    logic [TAG_W-1:0]    node_tag;
    logic [WEIGHT_W-1:0] weight;
  } entry_t;

endpackage

>>> design/bounded_top_k_min_heap_core.sv
// ----------------------------------------------------------------------------
// bounded_top_k_min_heap_core: top-k selector on an array min-heap
// Keeps the heaviest candidates up to a capacity; drains them in array order.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_*      | in        | tdata: weight, node_tag, edge_index; tuser: opcode
//  m_*      | out       | tdata: entry_count, min_weight, out_*; tuser: accepted,
//           |           |        entry_valid; tlast: last
//  cfg_*    | in        | cfg_data: capacity (always ready)
//
// an insert walks the heap level by level, each level a read, then a compare
// and write, plus accept and response; a sift down also reads at the leaf
// where it stops. a new item is taken only in idle, after the response.
// a drain reads each entry, then loads it into the output register.
// rst is synchronous; the heap memory is not cleared, the fill count is.
// the output register holds a result until m_tready; the next item is taken
// while it waits, and work stalls only when a new result is due.
// ----------------------------------------------------------------------------
module bounded_top_k_min_heap_core
  import btkmh_pkg::*;
#(
  parameter int HEAP_DEPTH = HEAP_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // weight [31:0], node_tag [55:32], edge_index [63:56]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // opcode [0]
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // entry_count [6:0], min_weight [38:7], out_weight [70:39],
  // out_node_tag [94:71], out_edge_index [102:95], zero [103]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // accepted [0], entry_valid [1]
  output logic [OUT_USER_W-1:0] m_tuser,
  output logic                  m_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CNT_W-1:0]      cfg_data
);

  localparam int IW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int KW = CW + 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RD,
    ST_DN_CMP,
    ST_RESP,
    ST_DR_RD,
    ST_DR_LD
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    capacity;
  logic [CW-1:0]       fill;
  logic [CW-1:0]       eff_cap;
  logic [IW-1:0]       idx;
  logic [IW-1:0]       drain_idx;
  entry_t              cur;
  logic                acc;
  logic [WEIGHT_W-1:0] root_w;

  entry_t              mem [HEAP_DEPTH];
  entry_t              rd_a;
  entry_t              rd_b;
  logic                rd_en;
  logic [IW-1:0]       rd_addr_a;
  logic [IW-1:0]       rd_addr_b;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  entry_t              wr_data;

  logic [IW-1:0]       parent;
  logic [KW-1:0]       child_l;
  logic [KW-1:0]       child_r;
  logic                l_in;
  logic                r_in;
  logic                up_swap;
  logic                dn_l;
  logic                dn_r;
  logic                out_free;
  logic                o_load;
  logic                drain_last;
  entry_t              in_entry;

  logic [CNT_W-1:0]    o_count;
  logic [WEIGHT_W-1:0] o_min;
  logic                o_acc;
  logic                o_valid;
  entry_t              o_entry;
  logic                o_last;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign o_load    = out_free && (state == ST_RESP || state == ST_DR_LD);
  assign in_entry  = s_tdata;

  assign m_tdata = {1'b0, o_entry.edge_index, o_entry.node_tag, o_entry.weight,
                    o_min, o_count};
  assign m_tuser = {o_valid, o_acc};
  assign m_tlast = o_last;

  always_comb begin
    if (capacity == '0) begin
      eff_cap = CW'(1);
    end else if (capacity > CNT_W'(HEAP_DEPTH)) begin
      eff_cap = CW'(HEAP_DEPTH);
    end else begin
      eff_cap = CW'(capacity);
    end
  end

  assign parent     = (idx - IW'(1)) >> 1;
  assign child_l    = KW'({idx, 1'b0}) + KW'(1);
  assign child_r    = KW'({idx, 1'b0}) + KW'(2);
  assign l_in       = child_l < KW'(fill);
  assign r_in       = child_r < KW'(fill);
  assign up_swap    = cur.weight < rd_a.weight;
  // left wins ties between children
  assign dn_l       = l_in && (rd_a.weight < cur.weight) &&
                      (!r_in || rd_a.weight <= rd_b.weight);
  assign dn_r       = !dn_l && r_in && (rd_b.weight < cur.weight);
  assign drain_last = (CW'(drain_idx) + CW'(1)) == fill;

  // hole-based sift: the moving entry stays in cur and is written once at the end
  always_comb begin
    rd_en     = 1'b0;
    rd_addr_a = drain_idx;
    rd_addr_b = child_r[IW-1:0];
    wr_en     = 1'b0;
    wr_addr   = idx;
    wr_data   = cur;
    case (state)
      ST_UP_RD: begin
        if (idx == '0) begin
          wr_en = 1'b1;
        end else begin
          rd_en     = 1'b1;
          rd_addr_a = parent;
        end
      end
      ST_UP_CMP: begin
        wr_en   = 1'b1;
        wr_data = up_swap ? rd_a : cur;
      end
      ST_DN_RD: begin
        rd_en     = 1'b1;
        rd_addr_a = child_l[IW-1:0];
      end
      ST_DN_CMP: begin
        wr_en = 1'b1;
        if (dn_l) begin
          wr_data = rd_a;
        end else if (dn_r) begin
          wr_data = rd_b;
        end
      end
      ST_DR_RD: begin
        rd_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a <= mem[rd_addr_a];
      rd_b <= mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      capacity  <= CAPACITY_RESET;
      fill      <= '0;
      m_tvalid  <= 1'b0;
      idx       <= '0;
      drain_idx <= '0;
      acc       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (wr_en && wr_addr == '0) begin
        root_w <= wr_data.weight;
      end
      if (o_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cur <= in_entry;
            if (s_tuser == OP_DRAIN) begin
              acc       <= 1'b0;
              drain_idx <= '0;
              state     <= (fill == '0) ? ST_RESP : ST_DR_RD;
            end else if (fill < eff_cap) begin
              acc   <= 1'b1;
              idx   <= fill[IW-1:0];
              fill  <= fill + CW'(1);
              state <= ST_UP_RD;
            end else if (fill != '0 && in_entry.weight > root_w) begin
              acc   <= 1'b1;
              idx   <= '0;
              state <= ST_DN_RD;
            end else begin
              acc   <= 1'b0;
              state <= ST_RESP;
            end
          end
        end
        ST_UP_RD: begin
          state <= (idx == '0) ? ST_RESP : ST_UP_CMP;
        end
        ST_UP_CMP: begin
          if (up_swap) begin
            idx   <= parent;
            state <= ST_UP_RD;
          end else begin
            state <= ST_RESP;
          end
        end
        ST_DN_RD: begin
          state <= ST_DN_CMP;
        end
        ST_DN_CMP: begin
          if (dn_l) begin
            idx   <= child_l[IW-1:0];
            state <= ST_DN_RD;
          end else if (dn_r) begin
            idx   <= child_r[IW-1:0];
            state <= ST_DN_RD;
          end else begin
            state <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            o_acc    <= acc;
            o_count  <= CNT_W'(fill);
            o_min    <= (fill == '0) ? '0 : root_w;
            o_valid  <= 1'b0;
            o_entry  <= '0;
            o_last   <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        ST_DR_RD: begin
          state <= ST_DR_LD;
        end
        ST_DR_LD: begin
          if (out_free) begin
            o_acc    <= 1'b0;
            o_count  <= '0;
            o_min    <= '0;
            o_valid  <= 1'b1;
            o_entry  <= rd_a;
            o_last   <= drain_last;
            if (drain_last) begin
              fill  <= '0;
              state <= ST_IDLE;
            end else begin
              drain_idx <= drain_idx + IW'(1);
              state     <= ST_DR_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> tb/bounded_top_k_min_heap_core_test.sv
// ----------------------------------------------------------------------------
// bounded_top_k_min_heap_core_test: self-checking bench for the top-k heap
// Drives inserts and drains over the stream port and writes capacities over
// the config channel. A mirror of the heap predicts every result word.
// Directed cases come first, then random traffic under several
// backpressure mixes.
// ----------------------------------------------------------------------------
module bounded_top_k_min_heap_core_test
  import btkmh_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEAP_DEPTH = HEAP_DEPTH_DEFAULT;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic               accepted;
    logic [CNT_W-1:0]   entry_count;
    logic [WEIGHT_W-1:0] min_weight;
    logic               entry_valid;
    entry_t             entry;
    logic               last;
  } heap_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // weight [31:0], node_tag [55:32], edge_index [63:56]
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  // opcode [0]
  logic                  s_tuser = OP_INSERT;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // entry_count [6:0], min_weight [38:7], out_weight [70:39],
  // out_node_tag [94:71], out_edge_index [102:95], zero [103]
  logic [OUT_DATA_W-1:0] m_tdata;
  // accepted [0], entry_valid [1]
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CNT_W-1:0]      cfg_data = '0;

  // mirror of the heap contents and capacity register
  entry_t           mirror_heap [HEAP_DEPTH];
  int               mirror_fill = 0;
  logic [CNT_W-1:0] mirror_cap = CAPACITY_RESET;
  heap_result_t     heap_words_due [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int words_checked = 0;
  int quiet_cycles = 0;

  bounded_top_k_min_heap_core #(
    .HEAP_DEPTH(HEAP_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < 50)
      $display("mismatch on word %0d: %s got %0h want %0h", words_checked, what, got, want);
    mismatch_count++;
  endtask

  function automatic void exchange_entries(int a, int b);
    entry_t t;
    t = mirror_heap[a];
    mirror_heap[a] = mirror_heap[b];
    mirror_heap[b] = t;
  endfunction

  function automatic void queue_word(heap_result_t res);
    heap_words_due.insert(heap_words_due.size(), res);
  endfunction

  // update the mirror for one accepted word and queue the words it causes
  task automatic apply_heap_op(logic op, entry_t item);
    int limit, i, p, l, r, n, k;
    heap_result_t res;
    limit = (mirror_cap == 0) ? 1 : (mirror_cap > HEAP_DEPTH) ? HEAP_DEPTH : int'(mirror_cap);
    res.accepted = 1'b0;
    res.entry_count = '0;
    res.min_weight = '0;
    res.entry_valid = 1'b0;
    res.entry = '0;
    res.last = 1'b1;
    if (op == OP_INSERT) begin
      if (mirror_fill < limit) begin
        i = mirror_fill;
        mirror_heap[i] = item;
        mirror_fill++;
        while (i > 0) begin
          p = (i - 1) / 2;
          if (mirror_heap[i].weight < mirror_heap[p].weight) begin
            exchange_entries(i, p);
            i = p;
          end else begin
            break;
          end
        end
        res.accepted = 1'b1;
      end else if (item.weight > mirror_heap[0].weight) begin
        // full heap (or capacity lowered below the fill): replace root, sift down
        mirror_heap[0] = item;
        i = 0;
        n = mirror_fill;
        forever begin
          l = 2 * i + 1;
          r = 2 * i + 2;
          if (l >= n) break;
          if (r >= n) begin
            if (mirror_heap[l].weight < mirror_heap[i].weight) exchange_entries(l, i);
            break;
          end
          if (mirror_heap[l].weight < mirror_heap[i].weight &&
              mirror_heap[l].weight <= mirror_heap[r].weight) begin
            exchange_entries(l, i);
            i = l;
          end else if (mirror_heap[r].weight < mirror_heap[i].weight) begin
            exchange_entries(r, i);
            i = r;
          end else begin
            break;
          end
        end
        res.accepted = 1'b1;
      end
      res.entry_count = CNT_W'(mirror_fill);
      res.min_weight = (mirror_fill != 0) ? mirror_heap[0].weight : '0;
      queue_word(res);
    end else if (mirror_fill == 0) begin
      queue_word(res);
    end else begin
      for (k = 0; k < mirror_fill; k++) begin
        res.entry_valid = 1'b1;
        res.entry = mirror_heap[k];
        res.last = (k == mirror_fill - 1);
        queue_word(res);
      end
      mirror_fill = 0;
    end
  endtask

  always @(posedge clk) begin : check_words
    heap_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (heap_words_due.size() == 0) begin
        report_mismatch("word with nothing due, tdata low bits", m_tdata[31:0], '0);
      end else begin
        want = heap_words_due.pop_front();
        if (m_tuser[0] !== want.accepted)
          report_mismatch("accepted", 32'(m_tuser[0]), 32'(want.accepted));
        if (m_tdata[6:0] !== want.entry_count)
          report_mismatch("entry_count", 32'(m_tdata[6:0]), 32'(want.entry_count));
        if (m_tdata[38:7] !== want.min_weight)
          report_mismatch("min_weight", m_tdata[38:7], want.min_weight);
        if (m_tuser[1] !== want.entry_valid)
          report_mismatch("entry_valid", 32'(m_tuser[1]), 32'(want.entry_valid));
        if (m_tdata[70:39] !== want.entry.weight)
          report_mismatch("out_weight", m_tdata[70:39], want.entry.weight);
        if (m_tdata[94:71] !== want.entry.node_tag)
          report_mismatch("out_node_tag", 32'(m_tdata[94:71]), 32'(want.entry.node_tag));
        if (m_tdata[102:95] !== want.entry.edge_index)
          report_mismatch("out_edge_index", 32'(m_tdata[102:95]),
                          32'(want.entry.edge_index));
        if (m_tlast !== want.last)
          report_mismatch("last", 32'(m_tlast), 32'(want.last));
      end
      words_checked++;
    end
  end

  // ends the run when nothing moves on any channel for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("bounded_top_k_min_heap_core regression: fail");
        $finish;
      end
    end
  end

  task automatic wait_heap_idle();
    while (heap_words_due.size() != 0) @(negedge clk);
  endtask

  task automatic send_word(logic op, entry_t item);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata = item;
    s_tuser = op;
    do @(posedge clk); while (!s_tready);
    apply_heap_op(op, item);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic send_insert(logic [WEIGHT_W-1:0] w, logic [TAG_W-1:0] tag,
                             logic [EDGE_W-1:0] edge_no);
    entry_t item;
    item.weight = w;
    item.node_tag = tag;
    item.edge_index = edge_no;
    send_word(OP_INSERT, item);
  endtask

  task automatic send_drain();
    send_word(OP_DRAIN, '0);
  endtask

  task automatic set_capacity(logic [CNT_W-1:0] value);
    wait_heap_idle();
    cfg_valid = 1'b1;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    mirror_cap = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_field_extremes();
    send_drain();
    send_insert(32'h0000_0000, 24'h00_0000, 8'h00);
    send_insert(32'hFFFF_FFFF, 24'hFF_FFFF, 8'hFF);
    send_insert(32'h8000_0000, 24'h55_5555, 8'hAA);
    send_insert(32'h7FFF_FFFF, 24'hAA_AAAA, 8'h55);
    send_drain();
  endtask

  task automatic test_capacity_clamp();
    // zero capacity acts as one
    set_capacity(7'd0);
    send_insert(32'd10, 24'h00_0001, 8'h01);
    send_insert(32'd5, 24'h00_0002, 8'h02);
    send_insert(32'd10, 24'h00_0003, 8'h03);
    send_insert(32'd11, 24'h00_0004, 8'h04);
    send_drain();
  endtask

  task automatic test_capacity_shrink();
    // above the depth acts as the depth
    set_capacity(7'd127);
    send_insert(32'd30, 24'h10_0000, 8'h10);
    send_insert(32'd10, 24'h20_0000, 8'h20);
    send_insert(32'd20, 24'h30_0000, 8'h30);
    send_insert(32'd40, 24'h40_0000, 8'h40);
    send_insert(32'd10, 24'h50_0000, 8'h50);
    send_insert(32'd50, 24'h60_0000, 8'h60);
    // fill stays at six, heap counts as full
    set_capacity(7'd2);
    send_insert(32'd5, 24'h70_0000, 8'h70);
    send_insert(32'd10, 24'h80_0000, 8'h80);
    send_insert(32'd60, 24'h90_0000, 8'h90);
    send_drain();
  endtask

  task automatic run_segment(logic [CNT_W-1:0] cap, int count, int drain_pct);
    entry_t item;
    logic   op;
    set_capacity(cap);
    repeat (count) begin
      op = ($urandom_range(99) < drain_pct) ? OP_DRAIN : OP_INSERT;
      item.node_tag = TAG_W'($urandom);
      item.edge_index = EDGE_W'($urandom);
      // mix of full range, ties and values near the ends
      case ($urandom_range(9))
        5, 6: item.weight = $urandom_range(15);
        7: item.weight = 32'hFFFF_FFFF - $urandom_range(3);
        8: item.weight = $urandom_range(3);
        9: item.weight = 32'h8000_0000 ^ $urandom_range(255);
        default: item.weight = $urandom;
      endcase
      send_word(op, item);
      if ($urandom_range(99) < 2) wait_heap_idle();
    end
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_segment(7'd64, 130, 0);
    send_drain();
    send_idle_pct = 63;
    run_segment(7'd1, 30, 10);
    run_segment(7'd5, 70, 8);
    send_idle_pct = 0;
    recv_stall_pct = 63;
    run_segment(7'd127, 40, 5);
    run_segment(7'd3, 60, 6);
    send_idle_pct = 30;
    recv_stall_pct = 30;
    run_segment(7'd0, 20, 10);
    run_segment(CNT_W'($urandom_range(63, 2)), 110, 4);
    send_drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_field_extremes();
    test_capacity_clamp();
    test_capacity_shrink();
    test_random_traffic();
    wait_heap_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && heap_words_due.size() == 0) begin
      $display("bounded_top_k_min_heap_core regression: pass");
    end else begin
      $display("bounded_top_k_min_heap_core regression: fail");
    end
    $finish;
  end

endmodule
